// ===== sv/inverse_square_field_sum_assert.svh =====
// ----------------------------------------------------------------------------
// inverse_square_field_sum_assert.svh
// Assertion macros for the inverse-square field sum block.
// ----------------------------------------------------------------------------
`ifndef INVERSE_SQUARE_FIELD_SUM_ASSERT_SVH
`define INVERSE_SQUARE_FIELD_SUM_ASSERT_SVH

`ifndef ASSERT_OFF
`define ISFS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ISFS_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ISFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISFS_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== sv/isfs_pkg.sv =====
// ----------------------------------------------------------------------------
// isfs_pkg
// Types and constants shared by the inverse-square field sum block.
// ----------------------------------------------------------------------------
package isfs_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 1024;
	localparam int unsigned QW    = 32;          // sample width
	localparam int unsigned NW    = 33;          // kernel quotient width
	localparam int unsigned PW    = QW + NW + 1; // product width
	localparam int unsigned TW    = PW - 16;     // rounded term width
	localparam int unsigned EW    = 64;          // result width
	localparam int unsigned POS_W = 10;

	localparam logic [NW-1:0] K_ONE = {1'b1, 32'b0};
	localparam logic [PW-1:0] RND_HALF = PW'(32768);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_COMPUTE,
		PH_READ
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic              skip;
		logic              sub;
		logic              first;
		logic              endj;
		logic              fin;
		logic signed [QW-1:0] q;
	} term_tag_t;

	typedef struct packed {
		logic              en;
		logic              fin;
		logic signed [EW-1:0] data;
	} res_wr_t;

endpackage

// ===== sv/isfs_div_cell.sv =====
// ----------------------------------------------------------------------------
// isfs_div_cell
// One restoring-division cell: settles one quotient bit and passes on.
// ----------------------------------------------------------------------------
module isfs_div_cell #(
	parameter int unsigned DW = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  isfs_pkg::term_tag_t    tag_in,
	input  logic [DW-1:0]          rem_in,
	input  logic [isfs_pkg::NW-1:0] num_in,
	input  logic [DW-1:0]          div_in,
	input  logic [isfs_pkg::NW-1:0] quo_in,
	output isfs_pkg::term_tag_t    tag_out,
	output logic [DW-1:0]          rem_out,
	output logic [isfs_pkg::NW-1:0] num_out,
	output logic [DW-1:0]          div_out,
	output logic [isfs_pkg::NW-1:0] quo_out
);
	import isfs_pkg::*;

	logic [DW:0] shifted;
	logic [DW:0] diff;
	logic        ge;

	assign shifted = {rem_in, num_in[NW-1]};
	assign diff    = shifted - {1'b0, div_in};
	assign ge      = shifted >= {1'b0, div_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_out <= ge ? diff[DW-1:0] : shifted[DW-1:0];
		num_out <= {num_in[NW-2:0], 1'b0};
		div_out <= div_in;
		quo_out <= {quo_in[NW-2:0], ge};
	end

endmodule

// ===== sv/isfs_kernel_chain.sv =====
// ----------------------------------------------------------------------------
// isfs_kernel_chain
// Row of division cells forming K(d) = round(2^32 / d^2), one per cycle.
// ----------------------------------------------------------------------------
module isfs_kernel_chain #(
	parameter int unsigned DW = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  isfs_pkg::term_tag_t     tag_in,
	input  logic [isfs_pkg::NW-1:0] dividend,
	input  logic [DW-1:0]           divisor,
	output isfs_pkg::term_tag_t     tag_out,
	output logic [isfs_pkg::NW-1:0] kernel
);
	import isfs_pkg::*;

	term_tag_t     tag [NW+1];
	logic [DW-1:0] rem [NW+1];
	logic [NW-1:0] num [NW+1];
	logic [DW-1:0] dv  [NW+1];
	logic [NW-1:0] quo [NW+1];

	assign tag[0] = tag_in;
	assign rem[0] = '0;
	assign num[0] = dividend;
	assign dv[0]  = divisor;
	assign quo[0] = '0;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		isfs_div_cell #(.DW(DW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tag_in  (tag[k]),
			.rem_in  (rem[k]),
			.num_in  (num[k]),
			.div_in  (dv[k]),
			.quo_in  (quo[k]),
			.tag_out (tag[k+1]),
			.rem_out (rem[k+1]),
			.num_out (num[k+1]),
			.div_out (dv[k+1]),
			.quo_out (quo[k+1])
		);
	end

	assign tag_out = tag[NW];
	assign kernel  = quo[NW];

endmodule

// ===== sv/isfs_term_acc.sv =====
// ----------------------------------------------------------------------------
// isfs_term_acc
// Multiplies sample by kernel, rounds to Q48.16 and saturating-accumulates.
// ----------------------------------------------------------------------------
module isfs_term_acc (
	input  logic                    clk,
	input  logic                    arst_n,
	input  isfs_pkg::term_tag_t     tag_in,
	input  logic [isfs_pkg::NW-1:0] kernel,
	output isfs_pkg::res_wr_t       wr
);
	import isfs_pkg::*;

	term_tag_t            tag_s1, tag_s2;
	logic signed [PW-1:0] prod_c, prod_s1;
	logic signed [PW-1:0] rsum, tfull;
	logic signed [TW-1:0] t_s2;
	logic signed [TW:0]   tv;
	logic signed [EW-1:0] acc_q, acc_in, sat;
	logic signed [EW+1:0] sum;
	res_wr_t              wr_q;

	assign prod_c = PW'(tag_in.q) * PW'(signed'({1'b0, kernel}));
	assign rsum   = prod_s1 + signed'(RND_HALF);
	assign tfull  = rsum >>> 16;

	assign acc_in = tag_s2.first ? '0 : acc_q;
	assign tv     = tag_s2.sub ? -((TW+1)'(t_s2)) : (TW+1)'(t_s2);
	assign sum    = (EW+2)'(acc_in) + (EW+2)'(tv);

	always_comb begin
		if ((sum[EW+1] == sum[EW]) && (sum[EW] == sum[EW-1])) begin
			sat = sum[EW-1:0];
		end else if (!sum[EW+1]) begin
			sat = {1'b0, {(EW-1){1'b1}}};
		end else begin
			sat = {1'b1, {(EW-1){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			wr_q   <= '0;
		end else begin
			tag_s1  <= tag_in;
			tag_s2  <= tag_s1;
			wr_q.en <= tag_s2.valid && tag_s2.endj;
			wr_q.fin <= tag_s2.valid && tag_s2.fin;
			wr_q.data <= sat;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		t_s2    <= tag_s1.skip ? '0 : tfull[TW-1:0];
		if (tag_s2.valid) begin
			acc_q <= sat;
		end
	end

	assign wr = wr_q;

endmodule

// ===== sv/inverse_square_field_sum.sv =====
// ----------------------------------------------------------------------------
// inverse_square_field_sum
// Signed field sum over a loaded sample set against a 1/d^2 kernel.
// ----------------------------------------------------------------------------
// Load and fetch beats are taken one per cycle unless a response waits on
// rsp_ready. The sample flagged last starts a compute burst for n samples, during
// which req_ready is low: one term per cycle is issued over all (j, i) pairs, the
// kernel for each distance is formed by a 33-cell division chain and accumulated
// in a single saturating adder, so the n*n term loop sets the burst length. A
// fetch taken in the read phase returns its result from the result memory the next cycle.
`include "inverse_square_field_sum_assert.svh"

module inverse_square_field_sum #(
	parameter int unsigned MAX_SAMPLES = isfs_pkg::MAX_SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        cmd,
	input  logic signed [isfs_pkg::QW-1:0] q_value,
	input  logic                        last_sample,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic signed [isfs_pkg::EW-1:0] e_value,
	output logic [isfs_pkg::POS_W-1:0]  position,
	output logic                        last_result
);
	import isfs_pkg::*;

	localparam int unsigned AW = $clog2(MAX_SAMPLES);
	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned DW = 2 * AW;

	logic signed [QW-1:0] sample_mem [MAX_SAMPLES];
	logic signed [EW-1:0] result_mem [MAX_SAMPLES];

	phase_t        phase_q, phase_d;
	logic [CW-1:0] count_q, cnt_base, cnt_m1;
	logic [AW-1:0] rp_q, i_q, j_q, wrj_q;
	logic          issue_q;
	logic          busy, reading, room, rp_last, i_end, j_end;
	logic          acc_any, load_acc, fetch_acc;

	term_tag_t     tag_i, tag_s1, tag_s2, tag_k, tag_m;
	logic [AW-1:0] d_s1;
	logic signed [QW-1:0] q_rd_s1;
	logic [DW-1:0] sq_s2;
	logic [NW-1:0] dividend, kern;
	res_wr_t       wr;

	logic          out_valid_q, last_q;
	logic [POS_W-1:0] pos_q;
	logic signed [EW-1:0] e_q;

	assign acc_any   = req_valid && req_ready;
	assign load_acc  = acc_any && (cmd == CMD_LOAD);
	assign fetch_acc = acc_any && (cmd == CMD_FETCH);

	assign cnt_base = (phase_q == PH_READ) ? '0 : count_q;
	assign room     = cnt_base < CW'(MAX_SAMPLES);
	assign cnt_m1   = count_q - CW'(1);
	assign rp_last  = (CW'(rp_q) + CW'(1)) == count_q;
	assign i_end    = CW'(i_q) == cnt_m1;
	assign j_end    = CW'(j_q) == cnt_m1;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_LOAD: begin
				if (load_acc && last_sample) phase_d = PH_COMPUTE;
			end
			PH_COMPUTE: begin
				if (wr.en && wr.fin) phase_d = PH_READ;
			end
			PH_READ: begin
				if (load_acc) begin
					phase_d = last_sample ? PH_COMPUTE : PH_LOAD;
				end else if (fetch_acc && rp_last) begin
					phase_d = PH_LOAD;
				end
			end
			default: phase_d = PH_LOAD;
		endcase
	end

	always_comb begin
		busy    = 1'b0;
		reading = 1'b0;
		unique case (phase_q)
			PH_COMPUTE: busy    = 1'b1;
			PH_READ:    reading = 1'b1;
			default: ;
		endcase
	end

	assign req_ready = !busy && (!out_valid_q || rsp_ready);

	always_comb begin
		tag_m   = tag_s1;
		tag_m.q = q_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOAD;
			count_q <= '0;
			rp_q    <= '0;
			issue_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			wrj_q   <= '0;
			tag_s1  <= '0;
			tag_s2  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (load_acc) begin
				count_q <= cnt_base + CW'(room);
				rp_q    <= '0;
			end else if (fetch_acc && reading) begin
				if (rp_last) begin
					count_q <= '0;
					rp_q    <= '0;
				end else begin
					rp_q <= rp_q + AW'(1);
				end
			end
			if (load_acc && last_sample) begin
				issue_q <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
				wrj_q   <= '0;
			end else begin
				if (issue_q) begin
					if (i_end) begin
						i_q <= '0;
						if (j_end) begin
							issue_q <= 1'b0;
						end else begin
							j_q <= j_q + AW'(1);
						end
					end else begin
						i_q <= i_q + AW'(1);
					end
				end
				if (wr.en) wrj_q <= wrj_q + AW'(1);
			end
			tag_s1 <= tag_i;
			tag_s2 <= tag_m;
			if (fetch_acc && reading) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		tag_i       = '0;
		tag_i.valid = issue_q;
		tag_i.skip  = i_q == j_q;
		tag_i.sub   = i_q > j_q;
		tag_i.first = i_q == '0;
		tag_i.endj  = i_end;
		tag_i.fin   = i_end && j_end;
	end

	always_ff @(posedge clk) begin
		if (load_acc && room) begin
			sample_mem[cnt_base[AW-1:0]] <= q_value;
		end
		q_rd_s1 <= sample_mem[i_q];
		d_s1    <= (i_q > j_q) ? (i_q - j_q) : (j_q - i_q);
		sq_s2   <= DW'(d_s1) * DW'(d_s1);
		if (wr.en) begin
			result_mem[wrj_q] <= wr.data;
		end
		if (fetch_acc && reading) begin
			e_q    <= result_mem[rp_q];
			pos_q  <= POS_W'(rp_q);
			last_q <= rp_last;
		end
	end

	assign dividend = K_ONE + NW'(sq_s2 >> 1);

	isfs_kernel_chain #(.DW(DW)) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_s2),
		.dividend (dividend),
		.divisor  (sq_s2),
		.tag_out  (tag_k),
		.kernel   (kern)
	);

	isfs_term_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_in (tag_k),
		.kernel (kern),
		.wr     (wr)
	);

	assign rsp_valid   = out_valid_q;
	assign e_value     = e_q;
	assign position    = pos_q;
	assign last_result = last_q;

	`ISFS_NEVER(a_ready_in_compute, clk, arst_n, busy && req_ready, "ready during compute")
	`ISFS_ASSERT(a_wr_in_compute, clk, arst_n, wr.en |-> busy, "result write outside compute")
	`ISFS_ASSERT(a_fin_to_read, clk, arst_n, (wr.en && wr.fin) |=> (phase_q == PH_READ), "no readout after last write")
	`ISFS_ASSERT(a_rp_bound, clk, arst_n, reading |-> (CW'(rp_q) < count_q), "read pointer past count")

endmodule

// ===== tb/inverse_square_field_sum_tb.sv =====
// ----------------------------------------------------------------------------
// inverse_square_field_sum_tb
// Sends sample sets and fetches through the request channel, predicts each
// field sum with a local fixed-point model, and checks results in order.
// ----------------------------------------------------------------------------
class field_sum_board;
	int                 n_samples;
	logic signed [31:0] samples[1024];
	logic [1:0]         mode;       // 0 loading, 1 reading
	int                 rd_ptr;
	logic signed [63:0] sums[1024];
	logic signed [63:0] exp_e[$];
	logic [9:0]         exp_pos[$];
	logic               exp_last[$];
	int                 errors;
	int                 results_seen;
	int                 sets_done;

	function new();
		n_samples = 0;
		mode = 2'd0;
		rd_ptr = 0;
		errors = 0;
		results_seen = 0;
		sets_done = 0;
	endfunction

	function logic [63:0] kernel(int d);
		logic [63:0] sq;
		if (d <= 1) return 64'h1_0000_0000;
		sq = 64'(d * d);
		return ((64'h1_0000_0000) + sq / 64'd2) / sq;
	endfunction

	function logic signed [63:0] term(logic signed [31:0] q, logic [63:0] k);
		logic signed [95:0] p;
		p = $signed({{64{q[31]}}, q}) * $signed({32'b0, k});
		p = p + 96'sd32768;
		return 64'(p >>> 16);
	endfunction

	function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function void compute_sums();
		logic signed [63:0] acc;
		for (int j = 0; j < n_samples; j++) begin
			acc = '0;
			for (int i = 0; i < n_samples; i++) begin
				if (i < j) acc = sat_add(acc, term(samples[i], kernel(j - i)));
				else if (i > j) acc = sat_add(acc, -term(samples[i], kernel(i - j)));
			end
			sums[j] = acc;
		end
	endfunction

	function void note_request(logic c, logic signed [31:0] q, logic lst);
		if (c == isfs_pkg::CMD_LOAD) begin
			if (mode != 2'd0) begin
				mode = 2'd0;
				n_samples = 0;
				rd_ptr = 0;
			end
			if (n_samples < 1024) begin
				samples[n_samples] = q;
				n_samples++;
			end
			if (lst) begin
				compute_sums();
				rd_ptr = 0;
				mode = 2'd1;
			end
		end else if (mode == 2'd1 && rd_ptr < n_samples) begin
			exp_e.push_back(sums[rd_ptr]);
			exp_pos.push_back(10'(rd_ptr));
			exp_last.push_back(rd_ptr + 1 == n_samples);
			rd_ptr++;
			if (rd_ptr >= n_samples) begin
				mode = 2'd0;
				n_samples = 0;
				rd_ptr = 0;
				sets_done++;
			end
		end
	endfunction

	function void check_result(logic signed [63:0] e, logic [9:0] p, logic l);
		logic signed [63:0] ee;
		logic [9:0]         ep;
		logic               el;
		results_seen++;
		if (exp_e.size() == 0) begin
			$display("%0t: unexpected result e=%0d pos=%0d", $time, e, p);
			errors++;
			return;
		end
		ee = exp_e.pop_front();
		ep = exp_pos.pop_front();
		el = exp_last.pop_front();
		if (e !== ee) begin
			$display("%0t: e_value expected %0d actual %0d", $time, ee, e);
			errors++;
		end
		if (p !== ep) begin
			$display("%0t: position expected %0d actual %0d", $time, ep, p);
			errors++;
		end
		if (l !== el) begin
			$display("%0t: last_result expected %0b actual %0b", $time, el, l);
			errors++;
		end
	endfunction

	function int pending();
		return exp_e.size();
	endfunction
endclass

module inverse_square_field_sum_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic                cmd;
	logic signed [31:0]  q_value;
	logic                last_sample;
	logic                rsp_valid;
	logic                rsp_ready;
	logic signed [63:0]  e_value;
	logic [9:0]          position;
	logic                last_result;

	field_sum_board board;
	bit                  no_idle;
	int                  n_items;

	inverse_square_field_sum dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.cmd(cmd), .q_value(q_value), .last_sample(last_sample),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.e_value(e_value), .position(position), .last_result(last_result)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_beat(logic c, logic signed [31:0] q, logic lst);
		while (!no_idle && $urandom_range(99) < 13) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		q_value <= q;
		last_sample <= lst;
		do @(posedge clk); while (!req_ready);
		board.note_request(c, q, lst);
		n_items++;
	endtask

	task automatic go_idle();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_q(int kind);
		case (kind)
			0: return $urandom;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			default: return $signed(32'($urandom_range(4095))) - 2048;
		endcase
	endfunction

	// a full set: n loads then n or n+1 fetches (rarely at most n)
	task automatic run_set(int n, int kind);
		int nf;
		for (int i = 0; i < n; i++)
			send_beat(isfs_pkg::CMD_LOAD, rand_q(kind == 4 ? $urandom_range(3) : kind),
				i == n - 1);
		nf = ($urandom_range(9) == 0) ? $urandom_range(n) : n + $urandom_range(1);
		for (int i = 0; i < nf; i++)
			send_beat(isfs_pkg::CMD_FETCH, $urandom, 1'($urandom));
	endtask

	initial begin
		board = new();
		no_idle = 0;
		n_items = 0;
		req_valid = 0;
		cmd = 0;
		q_value = 0;
		last_sample = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_beat(isfs_pkg::CMD_FETCH, 0, 1'b0);
		send_beat(isfs_pkg::CMD_LOAD, 32'sh7FFF_FFFF, 1'b1);
		send_beat(isfs_pkg::CMD_FETCH, 0, 1'b1);
		send_beat(isfs_pkg::CMD_LOAD, 32'sh7FFF_FFFF, 1'b0);
		send_beat(isfs_pkg::CMD_LOAD, 32'sh8000_0000, 1'b0);
		send_beat(isfs_pkg::CMD_LOAD, 32'sh7FFF_FFFF, 1'b0);
		send_beat(isfs_pkg::CMD_LOAD, -1, 1'b1);
		send_beat(isfs_pkg::CMD_FETCH, 0, 1'b0);
		send_beat(isfs_pkg::CMD_LOAD, 32'sh0000_0100, 1'b0);
		send_beat(isfs_pkg::CMD_LOAD, 32'sh0000_0100, 1'b1);
		send_beat(isfs_pkg::CMD_FETCH, 0, 1'b0);
		send_beat(isfs_pkg::CMD_FETCH, 0, 1'b0);
		send_beat(isfs_pkg::CMD_FETCH, 0, 1'b0);
		go_idle();
		wait_drained();

		// random sets
		while (n_items < 650) begin
			if ($urandom_range(7) == 0)
				send_beat(1'($urandom), $urandom, 1'($urandom));
			else run_set($urandom_range(1, 12), $urandom_range(4));
			if ($urandom_range(9) == 0) begin
				go_idle();
				wait_drained();
			end
			no_idle = (n_items > 300 && n_items < 450);
		end
		go_idle();
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d request beats, closed %0d sample sets, checked %0d results.",
			n_items, board.sets_done, board.results_seen);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		rsp_ready = 0;
		@(posedge arst_n);
		forever begin
			rsp_ready <= no_idle || ($urandom_range(99) >= 13);
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				board.check_result(e_value, position, last_result);
		end
	end
endmodule

// ===== inverse_square_field_sum.f =====
+incdir+sv
sv/isfs_pkg.sv
sv/isfs_div_cell.sv
sv/isfs_kernel_chain.sv
sv/isfs_term_acc.sv
sv/inverse_square_field_sum.sv
tb/inverse_square_field_sum_tb.sv
